// File: rtl/tog_pkg.sv
// Shared types and constants for the torus occupancy grid free search block.
// Holds field widths, default grid parameters and the opcode encoding.
// No dependencies.
package tog_pkg;

  localparam int DEF_GRID_COLS  = 64;
  localparam int DEF_GRID_ROWS  = 64;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int OP_W    = 3;
  localparam int COORD_W = 6;
  localparam int RAD_W   = 3;
  localparam int POP_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_KILL   = 3'd1,
    OP_REVIVE = 3'd2,
    OP_SWAP   = 3'd3,
    OP_FIND   = 3'd4
  } tog_op_t;

endpackage

// File: rtl/torus_occupancy_grid_free_search.sv
// Torus occupancy grid with population count and free-neighbor search (top level).
// Find scans the (2r+1)x(2r+1) window around the cell (r = saturated radius) and stops early on a hit;
// initialize sweeps the whole grid and writes every cell occupied.
// One item at a time; the single occupancy RAM read port (one cell per cycle) sets the scan rate.
// Reset: a clearing pass writes every cell free; in_stall is high meanwhile.
// Depends on tog_pkg and tog_ram.
module torus_occupancy_grid_free_search #(
  parameter int GRID_COLS  = tog_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS  = tog_pkg::DEF_GRID_ROWS,
  parameter int MAX_RADIUS = tog_pkg::DEF_MAX_RADIUS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tog_pkg::OP_W-1:0]    in_opcode,
  input  logic [tog_pkg::COORD_W-1:0] in_cell_x,
  input  logic [tog_pkg::COORD_W-1:0] in_cell_y,
  input  logic [tog_pkg::COORD_W-1:0] in_other_x,
  input  logic [tog_pkg::COORD_W-1:0] in_other_y,
  input  logic [tog_pkg::RAD_W-1:0]   in_radius,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [tog_pkg::COORD_W-1:0] out_found_x,
  output logic [tog_pkg::COORD_W-1:0] out_found_y,
  output logic [tog_pkg::POP_W-1:0]   out_population
);

  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int CW         = $clog2(GRID_COLS);
  localparam int RW         = $clog2(GRID_ROWS);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int RADW       = $clog2(MAX_RADIUS + 1);
  localparam int DW         = $clog2(2 * MAX_RADIUS + 1);
  localparam int COORD_N    = 2 ** tog_pkg::COORD_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_FILL, S_UPD, S_SWAP_B, S_SWAP_WA, S_SWAP_WB,
    S_SETUP, S_SCAN, S_EMIT
  } state_t;

  state_t                    state_r;
  logic [AW-1:0]             sweep_r;
  logic [CNT_W-1:0]          live_r;
  logic [tog_pkg::OP_W-1:0]  op_r;
  logic [CW-1:0]             cx_r, ox_r, px_r, pend_x_r, res_x_r;
  logic [RW-1:0]             cy_r, oy_r, py_r, start_py_r, pend_y_r, res_y_r;
  logic [RADW-1:0]           rad_r, rcnt_r;
  logic [DW-1:0]             dx_r, dy_r;
  logic                      pend_r, issue_done_r, res_found_r, bit_a_r;
  logic                      out_valid_r, out_found_r;
  logic [tog_pkg::COORD_W-1:0] out_found_x_r, out_found_y_r;
  logic [tog_pkg::POP_W-1:0] out_population_r;

  logic [CW-1:0]   xmod_tab [COORD_N];
  logic [RW-1:0]   ymod_tab [COORD_N];
  logic [RADW-1:0] rad_sat;
  logic [AW-1:0]   addr_a, addr_b, scan_addr;
  logic [DW-1:0]   rad_ext, rad2;
  logic            ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic            accept, out_free, centre;
  logic [CW-1:0]   px_inc, px_dec;
  logic [RW-1:0]   py_inc, py_dec;

  for (genvar g = 0; g < COORD_N; g++) begin : g_mod
    assign xmod_tab[g] = CW'(g % GRID_COLS);
    assign ymod_tab[g] = RW'(g % GRID_ROWS);
  end

  assign rad_sat   = (in_radius > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(in_radius);
  assign addr_a    = AW'(cx_r * GRID_ROWS + cy_r);
  assign addr_b    = AW'(ox_r * GRID_ROWS + oy_r);
  assign scan_addr = AW'(px_r * GRID_ROWS + py_r);
  assign rad_ext   = DW'(rad_r);
  assign rad2      = DW'(rad_ext << 1);
  assign centre    = (dx_r == rad_ext) && (dy_r == rad_ext);
  assign px_inc    = (px_r == CW'(GRID_COLS - 1)) ? '0 : px_r + 1'b1;
  assign px_dec    = (px_r == '0) ? CW'(GRID_COLS - 1) : px_r - 1'b1;
  assign py_inc    = (py_r == RW'(GRID_ROWS - 1)) ? '0 : py_r + 1'b1;
  assign py_dec    = (py_r == '0) ? RW'(GRID_ROWS - 1) : py_r - 1'b1;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_a;
    ram_wdata = 1'b0;
    ram_raddr = addr_a;
    unique case (state_r)
      S_CLEAR, S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = (state_r == S_FILL);
      end
      S_UPD: begin
        if (op_r == tog_pkg::OP_KILL) begin
          ram_we = ram_rdata;
        end else begin
          ram_we = !ram_rdata;
        end
        ram_wdata = (op_r != tog_pkg::OP_KILL);
      end
      S_SWAP_B: ram_raddr = addr_b;
      S_SWAP_WA: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = bit_a_r;
      end
      S_SCAN: ram_raddr = scan_addr;
      default: ;
    endcase
  end

  tog_ram #(
    .WIDTH(1),
    .DEPTH(CELL_COUNT)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR, S_FILL: begin
          if (sweep_r == AW'(CELL_COUNT - 1)) begin
            sweep_r <= '0;
            if (state_r == S_FILL) begin
              live_r  <= CNT_W'(CELL_COUNT);
              state_r <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_opcode;
            cx_r    <= xmod_tab[in_cell_x];
            cy_r    <= ymod_tab[in_cell_y];
            ox_r    <= xmod_tab[in_other_x];
            oy_r    <= ymod_tab[in_other_y];
            rad_r   <= rad_sat;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          res_found_r <= 1'b0;
          res_x_r     <= '0;
          res_y_r     <= '0;
          px_r        <= cx_r;
          py_r        <= cy_r;
          rcnt_r      <= rad_r;
          unique case (op_r)
            tog_pkg::OP_INIT:   state_r <= S_FILL;
            tog_pkg::OP_KILL:   state_r <= S_UPD;
            tog_pkg::OP_REVIVE: state_r <= S_UPD;
            tog_pkg::OP_SWAP:   state_r <= S_SWAP_B;
            tog_pkg::OP_FIND:   state_r <= (rad_r == '0) ? S_EMIT : S_SETUP;
            default:            state_r <= S_EMIT;
          endcase
        end
        S_UPD: begin
          if (ram_we) begin
            live_r <= (op_r == tog_pkg::OP_KILL) ? live_r - 1'b1 : live_r + 1'b1;
          end
          state_r <= S_EMIT;
        end
        S_SWAP_B: begin
          bit_a_r <= ram_rdata;
          state_r <= S_SWAP_WA;
        end
        S_SWAP_WA: state_r <= S_SWAP_WB;
        S_SWAP_WB: state_r <= S_EMIT;
        S_SETUP: begin
          if (rcnt_r == '0) begin
            start_py_r   <= py_r;
            dx_r         <= '0;
            dy_r         <= '0;
            pend_r       <= 1'b0;
            issue_done_r <= 1'b0;
            state_r      <= S_SCAN;
          end else begin
            px_r   <= px_dec;
            py_r   <= py_dec;
            rcnt_r <= rcnt_r - 1'b1;
          end
        end
        S_SCAN: begin
          if (pend_r && !ram_rdata) begin
            res_found_r <= 1'b1;
            res_x_r     <= pend_x_r;
            res_y_r     <= pend_y_r;
            state_r     <= S_EMIT;
          end else if (issue_done_r) begin
            state_r <= S_EMIT;
          end else begin
            pend_r   <= !centre;
            pend_x_r <= px_r;
            pend_y_r <= py_r;
            if (dy_r == rad2) begin
              dy_r <= '0;
              py_r <= start_py_r;
              px_r <= px_inc;
              if (dx_r == rad2) begin
                issue_done_r <= 1'b1;
              end else begin
                dx_r <= dx_r + 1'b1;
              end
            end else begin
              dy_r <= dy_r + 1'b1;
              py_r <= py_inc;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_found_r      <= res_found_r;
            out_found_x_r    <= tog_pkg::COORD_W'(res_x_r);
            out_found_y_r    <= tog_pkg::COORD_W'(res_y_r);
            out_population_r <= tog_pkg::POP_W'(live_r);
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_found_x    = out_found_x_r;
  assign out_found_y    = out_found_y_r;
  assign out_population = out_population_r;

  a_no_write_idle_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_SCAN) |-> !ram_we)
    else $error("grid write outside an update step");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(CELL_COUNT))
    else $error("population above cell count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_x == '0 && out_found_y == '0))
    else $error("miss beat carries a coordinate");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second beat taken while an item is in flight");

endmodule

// File: rtl/tog_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Width and depth are parameters. No dependencies.
module tog_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
